// File: design/b64fd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64fd_pkg: shared types and constants for the base64 filtering decoder
// Holds the decode job passed from the front part to the back part.
// ----------------------------------------------------------------------------
package b64fd_pkg;

  // Number of decoded bytes a full group of four characters releases
  localparam int unsigned GroupBytes = 3;

  // Width of one gathered character value and of the gathered group
  localparam int unsigned SextetW = 6;
  localparam int unsigned GroupW  = 8 * GroupBytes;

  // Status codes carried on the final result of a text
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  // One decode job: up to three bytes, oldest in the top bits
  typedef struct packed {
    logic [GroupW-1:0] data;
    logic [1:0]        nbytes_m1;  // bytes in the job minus one
    logic              has_data;   // 0 for a bare end marker
    logic              last;       // job closes the text
    logic              status;     // end status, shown on the final byte
  } job_t;

endpackage

// File: design/b64fd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64fd_front: character filter and gatherer
// Maps each character to its 6-bit value, drops the rest, gathers groups of
// four and turns full groups and text ends into decode jobs.
// ----------------------------------------------------------------------------
module b64fd_front
  import b64fd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [17:0]        store;
  logic [17:0]        store_next;
  logic [1:0]         count;
  logic [1:0]         count_next;
  logic               accept;
  logic               kept;
  logic [SextetW-1:0] sextet;
  logic               group_done;
  logic [17:0]        store_after;
  logic [1:0]         count_after;

  // Classify a character: valid flag and 6-bit value
  function automatic logic [SextetW:0] sextet_of(input logic [7:0] c);
    logic [SextetW:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A)      r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2B)               r = {1'b1, 6'd62};
    else if (c == 8'h2F)               r = {1'b1, 6'd63};
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign {kept, sextet} = sextet_of(in_char);
  assign group_done     = kept && (count == 2'd3);

  // Gathered state once this character is counted
  always_comb begin
    if (kept) begin
      store_after = {store[11:0], sextet};
      count_after = count + 2'd1;
    end else begin
      store_after = store;
      count_after = count;
    end
  end

  // Build the job for a full group or for the end of the text
  always_comb begin
    q_job           = '0;
    q_job.has_data  = 1'b1;
    q_job.status    = STATUS_OK;
    if (group_done) begin
      q_job.data      = {store, sextet};
      q_job.nbytes_m1 = 2'd2;
      q_job.last      = in_last;
    end else begin
      q_job.last = 1'b1;
      case (count_after)
        2'd0: begin
          q_job.has_data = 1'b0;
        end
        2'd1: begin
          q_job.has_data = 1'b0;
          q_job.status   = STATUS_SHORT;
        end
        2'd2: begin
          q_job.data[23:16] = store_after[11:4];
        end
        default: begin
          q_job.data[23:8]  = {store_after[17:10], store_after[9:2]};
          q_job.nbytes_m1   = 2'd1;
        end
      endcase
    end
  end

  assign q_push = accept && (group_done || in_last);

  // Advance the gathered state; clear it on a full group or text end
  always_comb begin
    store_next = store;
    count_next = count;
    if (accept) begin
      if (group_done || in_last) begin
        store_next = '0;
        count_next = '0;
      end else begin
        store_next = store_after;
        count_next = count_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store <= '0;
      count <= '0;
    end else begin
      store <= store_next;
      count <= count_next;
    end
  end

endmodule

// File: design/b64fd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64fd_queue: two-entry job queue
// Decouples the character front from the byte back so each may stall alone.
// ----------------------------------------------------------------------------
module b64fd_queue
  import b64fd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slot[rd_ptr];

  // Store a pushed job
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= !wr_ptr;
      if (pop && !empty) rd_ptr <= !rd_ptr;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/b64fd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64fd_back: byte serialiser
// Sends the bytes of the head job one per cycle, while the output is taken, through an output register.
// ----------------------------------------------------------------------------
module b64fd_back
  import b64fd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  job_t       q_head,
  output logic       q_pop,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       out_last,
  output logic       status,
  output logic       out_valid,
  input  logic       out_ready
);

  logic [1:0] idx;
  logic       load;
  logic       final_byte;
  logic [7:0] sel_byte;

  assign load       = !q_empty && (!out_valid || out_ready);
  assign final_byte = (idx == q_head.nbytes_m1);
  assign q_pop      = load && final_byte;

  // Pick the current byte of the job, oldest first
  always_comb begin
    case (idx)
      2'd0:    sel_byte = q_head.data[23:16];
      2'd1:    sel_byte = q_head.data[15:8];
      default: sel_byte = q_head.data[7:0];
    endcase
  end

  // Hold the output request until taken; load the next byte when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= final_byte ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= sel_byte;
      byte_valid <= q_head.has_data;
      out_last   <= final_byte && q_head.last;
      status     <= final_byte && q_head.status;
    end
  end

endmodule

// File: design/base64_filter_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_filter_decoder: streaming base64 decoder with character filter
// Top level joining the character front, the job queue and the byte back.
// ----------------------------------------------------------------------------
// One text character is taken per cycle while the two-entry job queue has
// room; characters outside the base64 alphabet, padding included, are
// dropped. Every fourth kept character makes a job of three bytes, and the
// character flagged last makes a closing job (three bytes if it completes a
// group, else one or two bytes or a bare end marker, with status set for a
// single stray character). The back part sends one byte per cycle while the
// output is taken, so a steady stream of full groups keeps up with the input;
// only a stalled output or closely spaced text ends back-pressure the input.
// ----------------------------------------------------------------------------
module base64_filter_decoder
  import b64fd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_char,
  input  logic       in_last,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       out_last,
  output logic       status,
  output logic       out_valid,
  input  logic       out_ready
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  job_t q_job;
  job_t q_head;

  // Classify characters and build jobs
  b64fd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_char  (in_char),
    .in_last  (in_last),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_job)
  );

  // Buffer jobs between the two parts
  b64fd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Serialise jobs into output bytes
  b64fd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .out_last   (out_last),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  // Error status only on a bare final marker
  a_status_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> out_last && !byte_valid)
    else $error("status set on a result that is not a bare final marker");

  // A bare marker always closes the text
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_last)
    else $error("bare marker without end flag");

  // Never push a job into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // Never pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

endmodule
